// ----- rtl/hba_pkg.sv -----
package hba_pkg;

  localparam int unsigned HBA_HEAP_BYTES = 65536;
  localparam int unsigned HBA_META_BYTES = 32;
  localparam int unsigned HBA_FREE_SLOTS = 64;

  localparam int unsigned REQ_W  = 17;
  localparam int unsigned PAY_W  = 16;
  localparam int unsigned NEED_W = 18;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_ZERO  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CK, S_TAKE_LAST,
    S_SD_L, S_SD_LCK, S_SD_RCK, S_SD_DEC, S_SD_END,
    S_ALLOC_SPLIT, S_ALLOC_MARK,
    S_INS_START, S_SU_CHK, S_SU_CK, S_SU_END,
    S_FREE_CK, S_MG_START, S_MG_RD, S_MG_C, S_MG_N,
    S_RM_RD, S_RM_CK, S_MG_RM2, S_MG_JOIN, S_MG_CLR, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    RET_ALLOC_TAKE, RET_ALLOC_INS, RET_FREE_INS, RET_RM_CUR, RET_RM_NXT, RET_MG_INS
  } ret_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_SET_RES, OP_OUT, OP_IDX_CLR, OP_IDX_INC,
    OP_FA_RD_IDX, OP_TAKE_FIT, OP_TAKE, OP_E_LAST, OP_SD_RD_L, OP_SD_LCK,
    OP_SD_RCK, OP_SD_MOVE, OP_E_WRITE, OP_E_WRITE_INC, OP_SPLIT, OP_MARK_USED,
    OP_INS_START, OP_SU_RD, OP_SU_MOVE, OP_FREE_RD, OP_FREE_MARK, OP_CUR_CLR,
    OP_MG_RD, OP_MG_C, OP_RM_CUR, OP_RM_NXT, OP_MG_JOIN, OP_MG_CLR, OP_CUR_NEXT
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic is_alloc;
    logic zero_size;
    logic ptr_zero;
    logic ptr_bad;
    logic idx_lt_cnt;
    logic fit;
    logic l_lt_cnt;
    logic r_lt_cnt;
    logic best_self;
    logic split_ok;
    logic cnt_full;
    logic idx_zero;
    logic parent_gt;
    logic c_bad;
    logic free_bad;
    logic nxt_over;
    logic n_bad;
    logic both_free;
    logic rm_hit;
    logic out_free;
  } flags_t;

endpackage

// ----- rtl/hba_ctrl.sv -----
module hba_ctrl import hba_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  flags_t flags_i,
  output cmd_t   cmd_o,
  output logic   in_ready_o
);

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;

  function automatic state_e ret_state(input ret_e r);
    state_e s;
    s = S_MG_RD;
    unique case (r)
      RET_ALLOC_TAKE: s = S_ALLOC_SPLIT;
      RET_ALLOC_INS:  s = S_ALLOC_MARK;
      RET_FREE_INS:   s = S_MG_START;
      RET_RM_CUR:     s = S_MG_RM2;
      RET_RM_NXT:     s = S_MG_JOIN;
      RET_MG_INS:     s = S_MG_RD;
      default:        s = S_MG_RD;
    endcase
    return s;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ret_q   <= RET_ALLOC_TAKE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    ret_d         = ret_q;
    cmd_o.op      = OP_NONE;
    cmd_o.status  = ST_OK;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_INIT;
        if (flags_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (flags_i.is_alloc) begin
          if (flags_i.zero_size) begin
            cmd_o.op     = OP_SET_RES;
            cmd_o.status = ST_ZERO;
            state_d      = S_DONE;
          end else begin
            cmd_o.op = OP_IDX_CLR;
            state_d  = S_SCAN_RD;
          end
        end else if (flags_i.ptr_zero) begin
          cmd_o.op = OP_SET_RES;
          state_d  = S_DONE;
        end else if (flags_i.ptr_bad) begin
          cmd_o.op     = OP_SET_RES;
          cmd_o.status = ST_RANGE;
          state_d      = S_DONE;
        end else begin
          cmd_o.op = OP_FREE_RD;
          state_d  = S_FREE_CK;
        end
      end
      S_SCAN_RD: begin
        if (flags_i.idx_lt_cnt) begin
          cmd_o.op = OP_FA_RD_IDX;
          state_d  = S_SCAN_CK;
        end else begin
          cmd_o.op     = OP_SET_RES;
          cmd_o.status = ST_NOFIT;
          state_d      = S_DONE;
        end
      end
      S_SCAN_CK: begin
        if (flags_i.fit) begin
          cmd_o.op = OP_TAKE_FIT;
          ret_d    = RET_ALLOC_TAKE;
          state_d  = S_TAKE_LAST;
        end else begin
          cmd_o.op = OP_IDX_INC;
          state_d  = S_SCAN_RD;
        end
      end
      S_TAKE_LAST: begin
        cmd_o.op = OP_E_LAST;
        state_d  = S_SD_L;
      end
      S_SD_L: begin
        if (flags_i.l_lt_cnt) begin
          cmd_o.op = OP_SD_RD_L;
          state_d  = S_SD_LCK;
        end else begin
          state_d = S_SD_END;
        end
      end
      S_SD_LCK: begin
        cmd_o.op = OP_SD_LCK;
        state_d  = flags_i.r_lt_cnt ? S_SD_RCK : S_SD_DEC;
      end
      S_SD_RCK: begin
        cmd_o.op = OP_SD_RCK;
        state_d  = S_SD_DEC;
      end
      S_SD_DEC: begin
        if (flags_i.best_self) begin
          state_d = S_SD_END;
        end else begin
          cmd_o.op = OP_SD_MOVE;
          state_d  = S_SD_L;
        end
      end
      S_SD_END: begin
        cmd_o.op = OP_E_WRITE;
        state_d  = ret_state(ret_q);
      end
      S_ALLOC_SPLIT: begin
        if (flags_i.split_ok) begin
          cmd_o.op = OP_SPLIT;
          ret_d    = RET_ALLOC_INS;
          state_d  = S_INS_START;
        end else begin
          state_d = S_ALLOC_MARK;
        end
      end
      S_ALLOC_MARK: begin
        cmd_o.op = OP_MARK_USED;
        state_d  = S_DONE;
      end
      S_INS_START: begin
        if (flags_i.cnt_full) begin
          state_d = ret_state(ret_q);
        end else begin
          cmd_o.op = OP_INS_START;
          state_d  = S_SU_CHK;
        end
      end
      S_SU_CHK: begin
        if (flags_i.idx_zero) begin
          state_d = S_SU_END;
        end else begin
          cmd_o.op = OP_SU_RD;
          state_d  = S_SU_CK;
        end
      end
      S_SU_CK: begin
        if (flags_i.parent_gt) begin
          cmd_o.op = OP_SU_MOVE;
          state_d  = S_SU_CHK;
        end else begin
          state_d = S_SU_END;
        end
      end
      S_SU_END: begin
        cmd_o.op = OP_E_WRITE_INC;
        state_d  = ret_state(ret_q);
      end
      S_FREE_CK: begin
        if (flags_i.free_bad) begin
          cmd_o.op     = OP_SET_RES;
          cmd_o.status = ST_RANGE;
          state_d      = S_DONE;
        end else begin
          cmd_o.op = OP_FREE_MARK;
          ret_d    = RET_FREE_INS;
          state_d  = S_INS_START;
        end
      end
      S_MG_START: begin
        cmd_o.op = OP_CUR_CLR;
        state_d  = S_MG_RD;
      end
      S_MG_RD: begin
        cmd_o.op = OP_MG_RD;
        state_d  = S_MG_C;
      end
      S_MG_C: begin
        if (flags_i.c_bad || flags_i.nxt_over) begin
          cmd_o.op = OP_SET_RES;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_MG_C;
          state_d  = S_MG_N;
        end
      end
      S_MG_N: begin
        if (flags_i.n_bad) begin
          cmd_o.op = OP_SET_RES;
          state_d  = S_DONE;
        end else if (flags_i.both_free) begin
          cmd_o.op = OP_RM_CUR;
          ret_d    = RET_RM_CUR;
          state_d  = S_RM_RD;
        end else begin
          cmd_o.op = OP_CUR_NEXT;
          state_d  = S_MG_RD;
        end
      end
      S_RM_RD: begin
        if (flags_i.idx_lt_cnt) begin
          cmd_o.op = OP_FA_RD_IDX;
          state_d  = S_RM_CK;
        end else begin
          state_d = ret_state(ret_q);
        end
      end
      S_RM_CK: begin
        if (flags_i.rm_hit) begin
          cmd_o.op = OP_TAKE;
          state_d  = S_TAKE_LAST;
        end else begin
          cmd_o.op = OP_IDX_INC;
          state_d  = S_RM_RD;
        end
      end
      S_MG_RM2: begin
        cmd_o.op = OP_RM_NXT;
        ret_d    = RET_RM_NXT;
        state_d  = S_RM_RD;
      end
      S_MG_JOIN: begin
        cmd_o.op = OP_MG_JOIN;
        state_d  = S_MG_CLR;
      end
      S_MG_CLR: begin
        cmd_o.op = OP_MG_CLR;
        ret_d    = RET_MG_INS;
        state_d  = S_INS_START;
      end
      S_DONE: begin
        if (flags_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/hba_dpath.sv -----
module hba_dpath import hba_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HBA_HEAP_BYTES,
  parameter int unsigned META_BYTES = HBA_META_BYTES,
  parameter int unsigned FREE_SLOTS = HBA_FREE_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output flags_t           flags_o,
  input  logic             req_type_i,
  input  logic [REQ_W-1:0] req_size_i,
  input  logic [REQ_W-1:0] payload_offset_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PAY_W-1:0] payload_offset_o,
  output logic [1:0]       status_o
);

  localparam int unsigned OFF_W     = $clog2(HEAP_BYTES);
  localparam int unsigned HDR_DEPTH = HEAP_BYTES / 8;
  localparam int unsigned HA_W      = $clog2(HDR_DEPTH);
  localparam int unsigned HDR_W     = 2 + 2 * OFF_W;
  localparam int unsigned FA_W      = 2 * OFF_W;
  localparam int unsigned IDX_W     = $clog2(FREE_SLOTS);
  localparam int unsigned CNT_W     = $clog2(FREE_SLOTS + 1);
  localparam int unsigned NW        = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 2;

  localparam logic [NW-1:0]    HEAP_N    = NW'(HEAP_BYTES);
  localparam logic [NW-1:0]    META_N    = NW'(META_BYTES);
  localparam logic [NW-1:0]    SPLIT_MIN = NW'(META_BYTES + 16);
  localparam logic [OFF_W-1:0] INIT_SIZE = OFF_W'(HEAP_BYTES - META_BYTES);
  localparam logic [HA_W-1:0]  CLR_LAST  = HA_W'(HDR_DEPTH - 1);
  localparam logic [CNT_W-1:0] SLOTS_C   = CNT_W'(FREE_SLOTS);

  logic [HDR_W-1:0] hdr_mem [HDR_DEPTH];
  logic [FA_W-1:0]  fa_mem  [FREE_SLOTS];

  logic [HDR_W-1:0] hdr_rd_q;
  logic [FA_W-1:0]  fa_rd_q;

  logic              hdr_we, hdr_re, fa_we, fa_re;
  logic [HA_W-1:0]   hdr_wa, hdr_ra;
  logic [HDR_W-1:0]  hdr_wd;
  logic [IDX_W-1:0]  fa_wa, fa_ra;
  logic [FA_W-1:0]   fa_wd;

  logic              req_free_q;
  logic [NEED_W-1:0] need_q;
  logic [REQ_W-1:0]  ptr_q;
  logic [CNT_W-1:0]  cnt_q, idx_q;
  logic [OFF_W-1:0]  e_off_q, e_size_q, b_off_q, b_size_q, n_off_q, n_size_q, rm_off_q;
  logic              b_free_q;
  logic [CNT_W:0]    best_idx_q;
  logic              best_self_q;
  logic [OFF_W-1:0]  best_off_q, best_size_q;
  logic [HA_W-1:0]   clr_q;
  logic [PAY_W-1:0]  res_pay_q, out_pay_q;
  status_e           res_status_q, out_status_q;
  logic              out_valid_q;

  logic              h_valid, h_free;
  logic [OFF_W-1:0]  h_off, h_size, f_off, f_size;
  logic [CNT_W:0]    lc, rc;
  logic [CNT_W-1:0]  parent, cnt_m1;
  logic [NW-1:0]     nxt, ptr_off, noff_n, rest_n, join_n, pay_n;
  logic [NEED_W-1:0] need_sum;

  function automatic logic [HA_W-1:0] hidx(input logic [OFF_W-1:0] off);
    logic [OFF_W-1:0] g;
    g = off >> 3;
    if (g < OFF_W'(HDR_DEPTH)) return g[HA_W-1:0];
    return '0;
  endfunction

  assign h_valid = hdr_rd_q[HDR_W-1];
  assign h_free  = hdr_rd_q[HDR_W-2];
  assign h_off   = hdr_rd_q[2*OFF_W-1:OFF_W];
  assign h_size  = hdr_rd_q[OFF_W-1:0];
  assign f_off   = fa_rd_q[FA_W-1:OFF_W];
  assign f_size  = fa_rd_q[OFF_W-1:0];

  assign lc       = {idx_q, 1'b1};
  assign rc       = lc + (CNT_W+1)'(1);
  assign parent   = (idx_q - CNT_W'(1)) >> 1;
  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign nxt      = NW'(b_off_q) + META_N + NW'(h_size);
  assign ptr_off  = NW'(ptr_q) - META_N;
  assign noff_n   = NW'(b_off_q) + META_N + NW'(need_q);
  assign rest_n   = NW'(b_size_q) - NW'(need_q) - META_N;
  assign join_n   = NW'(b_size_q) + META_N + NW'(n_size_q);
  assign pay_n    = NW'(b_off_q) + META_N;
  assign need_sum = NEED_W'(req_size_i) + NEED_W'(7);

  always_comb begin
    flags_o.init_last  = clr_q == CLR_LAST;
    flags_o.is_alloc   = !req_free_q;
    flags_o.zero_size  = need_q == '0;
    flags_o.ptr_zero   = ptr_q == '0;
    flags_o.ptr_bad    = (NW'(ptr_q) < META_N) || (ptr_off >= HEAP_N);
    flags_o.idx_lt_cnt = idx_q < cnt_q;
    flags_o.fit        = NW'(f_size) >= NW'(need_q);
    flags_o.l_lt_cnt   = lc < {1'b0, cnt_q};
    flags_o.r_lt_cnt   = rc < {1'b0, cnt_q};
    flags_o.best_self  = best_self_q;
    flags_o.split_ok   = NW'(b_size_q) >= NW'(need_q) + SPLIT_MIN;
    flags_o.cnt_full   = cnt_q >= SLOTS_C;
    flags_o.idx_zero   = idx_q == '0;
    flags_o.parent_gt  = f_size > e_size_q;
    flags_o.c_bad      = !h_valid || (h_off != b_off_q);
    flags_o.free_bad   = !h_valid || (h_off != b_off_q) || h_free;
    flags_o.nxt_over   = nxt >= HEAP_N;
    flags_o.n_bad      = !h_valid || (h_off != n_off_q);
    flags_o.both_free  = b_free_q && h_free;
    flags_o.rm_hit     = f_off == rm_off_q;
    flags_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    hdr_we = 1'b0;
    hdr_re = 1'b0;
    hdr_wa = '0;
    hdr_ra = '0;
    hdr_wd = '0;
    fa_we  = 1'b0;
    fa_re  = 1'b0;
    fa_wa  = '0;
    fa_ra  = '0;
    fa_wd  = '0;
    unique case (cmd_i.op)
      OP_INIT: begin
        hdr_we = 1'b1;
        hdr_wa = clr_q;
        hdr_wd = (clr_q == '0) ? {2'b11, OFF_W'(0), INIT_SIZE} : '0;
        fa_we  = 1'b1;
        fa_wd  = {OFF_W'(0), INIT_SIZE};
      end
      OP_FA_RD_IDX: begin
        fa_re = 1'b1;
        fa_ra = idx_q[IDX_W-1:0];
      end
      OP_TAKE_FIT, OP_TAKE: begin
        fa_re = 1'b1;
        fa_ra = cnt_m1[IDX_W-1:0];
      end
      OP_SD_RD_L: begin
        fa_re = 1'b1;
        fa_ra = lc[IDX_W-1:0];
      end
      OP_SD_LCK: begin
        fa_re = 1'b1;
        fa_ra = rc[IDX_W-1:0];
      end
      OP_SD_MOVE: begin
        fa_we = 1'b1;
        fa_wa = idx_q[IDX_W-1:0];
        fa_wd = {best_off_q, best_size_q};
      end
      OP_E_WRITE, OP_E_WRITE_INC: begin
        fa_we = 1'b1;
        fa_wa = idx_q[IDX_W-1:0];
        fa_wd = {e_off_q, e_size_q};
      end
      OP_SPLIT: begin
        hdr_we = 1'b1;
        hdr_wa = hidx(noff_n[OFF_W-1:0]);
        hdr_wd = {2'b11, noff_n[OFF_W-1:0], rest_n[OFF_W-1:0]};
      end
      OP_MARK_USED: begin
        hdr_we = 1'b1;
        hdr_wa = hidx(b_off_q);
        hdr_wd = {2'b10, b_off_q, b_size_q};
      end
      OP_SU_RD: begin
        fa_re = 1'b1;
        fa_ra = parent[IDX_W-1:0];
      end
      OP_SU_MOVE: begin
        fa_we = 1'b1;
        fa_wa = idx_q[IDX_W-1:0];
        fa_wd = fa_rd_q;
      end
      OP_FREE_RD: begin
        hdr_re = 1'b1;
        hdr_ra = hidx(ptr_off[OFF_W-1:0]);
      end
      OP_FREE_MARK: begin
        hdr_we = 1'b1;
        hdr_wa = hidx(b_off_q);
        hdr_wd = {2'b11, b_off_q, h_size};
      end
      OP_MG_RD: begin
        hdr_re = 1'b1;
        hdr_ra = hidx(b_off_q);
      end
      OP_MG_C: begin
        hdr_re = 1'b1;
        hdr_ra = hidx(nxt[OFF_W-1:0]);
      end
      OP_MG_JOIN: begin
        hdr_we = 1'b1;
        hdr_wa = hidx(b_off_q);
        hdr_wd = {2'b11, b_off_q, join_n[OFF_W-1:0]};
      end
      OP_MG_CLR: begin
        hdr_we = 1'b1;
        hdr_wa = hidx(n_off_q);
        hdr_wd = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    if (hdr_re) hdr_rd_q <= hdr_mem[hdr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fa_we) fa_mem[fa_wa] <= fa_wd;
    if (fa_re) fa_rd_q <= fa_mem[fa_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CNT_W'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_INIT) clr_q <= clr_q + HA_W'(1);
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.op == OP_TAKE_FIT || cmd_i.op == OP_TAKE) begin
        cnt_q <= cnt_m1;
      end else if (cmd_i.op == OP_E_WRITE_INC) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        req_free_q <= req_type_i;
        need_q     <= {need_sum[NEED_W-1:3], 3'b000};
        ptr_q      <= payload_offset_in_i;
      end
      OP_SET_RES: begin
        res_pay_q    <= '0;
        res_status_q <= cmd_i.status;
      end
      OP_OUT: begin
        out_pay_q    <= res_pay_q;
        out_status_q <= res_status_q;
      end
      OP_IDX_CLR: idx_q <= '0;
      OP_IDX_INC: idx_q <= idx_q + CNT_W'(1);
      OP_TAKE_FIT: begin
        b_off_q  <= f_off;
        b_size_q <= f_size;
      end
      OP_E_LAST: begin
        e_off_q  <= f_off;
        e_size_q <= f_size;
      end
      OP_SD_LCK: begin
        if (f_size < e_size_q) begin
          best_idx_q  <= lc;
          best_self_q <= 1'b0;
          best_off_q  <= f_off;
          best_size_q <= f_size;
        end else begin
          best_idx_q  <= {1'b0, idx_q};
          best_self_q <= 1'b1;
          best_off_q  <= e_off_q;
          best_size_q <= e_size_q;
        end
      end
      OP_SD_RCK: begin
        if (f_size < best_size_q) begin
          best_idx_q  <= rc;
          best_self_q <= 1'b0;
          best_off_q  <= f_off;
          best_size_q <= f_size;
        end
      end
      OP_SD_MOVE: idx_q <= best_idx_q[CNT_W-1:0];
      OP_SPLIT: begin
        e_off_q  <= noff_n[OFF_W-1:0];
        e_size_q <= rest_n[OFF_W-1:0];
        b_size_q <= need_q[OFF_W-1:0];
      end
      OP_MARK_USED: begin
        res_pay_q    <= pay_n[PAY_W-1:0];
        res_status_q <= ST_OK;
      end
      OP_INS_START: idx_q <= cnt_q;
      OP_SU_MOVE:   idx_q <= parent;
      OP_FREE_RD:   b_off_q <= ptr_off[OFF_W-1:0];
      OP_FREE_MARK: begin
        e_off_q  <= b_off_q;
        e_size_q <= h_size;
      end
      OP_CUR_CLR: b_off_q <= '0;
      OP_MG_C: begin
        b_size_q <= h_size;
        b_free_q <= h_free;
        n_off_q  <= nxt[OFF_W-1:0];
      end
      OP_RM_CUR: begin
        n_size_q <= h_size;
        rm_off_q <= b_off_q;
        idx_q    <= '0;
      end
      OP_RM_NXT: begin
        rm_off_q <= n_off_q;
        idx_q    <= '0;
      end
      OP_MG_JOIN: begin
        b_size_q <= join_n[OFF_W-1:0];
        e_off_q  <= b_off_q;
        e_size_q <= join_n[OFF_W-1:0];
      end
      OP_CUR_NEXT: b_off_q <= n_off_q;
      default: begin
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign payload_offset_o = out_pay_q;
  assign status_o         = out_status_q;

endmodule

// ----- rtl/heap_block_allocator.sv -----
// Heap block allocator: one request in, one result out per transfer. After reset a
// clearing pass over all HEAP_BYTES/8 header entries initializes the header memory;
// no request is taken meanwhile. One request is worked at a time by a sequencer over
// two single-port memories (block headers, free array as a min-heap on block size),
// one access each per cycle. Allocate scans the free array for the first entry that
// fits, removes it with a sift-down and, on a split, inserts the rest with a sift-up.
// Free walks the whole block chain, and each merge adds two free-array scans and the
// reheap steps. A result waits in an output register while the next request is
// accepted.
module heap_block_allocator import hba_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HBA_HEAP_BYTES,
  parameter int unsigned META_BYTES = HBA_META_BYTES,
  parameter int unsigned FREE_SLOTS = HBA_FREE_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             req_type_i,
  input  logic [REQ_W-1:0] req_size_i,
  input  logic [REQ_W-1:0] payload_offset_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PAY_W-1:0] payload_offset_o,
  output logic [1:0]       status_o
);

  cmd_t   cmd;
  flags_t flags;

  hba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .flags_i    (flags),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  hba_dpath #(
    .HEAP_BYTES (HEAP_BYTES),
    .META_BYTES (META_BYTES),
    .FREE_SLOTS (FREE_SLOTS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .flags_o             (flags),
    .req_type_i          (req_type_i),
    .req_size_i          (req_size_i),
    .payload_offset_in_i (payload_offset_in_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .payload_offset_o    (payload_offset_o),
    .status_o            (status_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_fail_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> payload_offset_o == '0)
    else $error("failed request returned an offset");
`endif

endmodule

// ----- dv/tb_heap_block_allocator.sv -----
module tb_heap_block_allocator;
  import hba_pkg::*;

  localparam int unsigned HEAP  = HBA_HEAP_BYTES;
  localparam int unsigned META  = HBA_META_BYTES;
  localparam int unsigned SLOTS = HBA_FREE_SLOTS;
  localparam int unsigned GRAN  = HEAP / 8;
  localparam bit REQ_ALLOC = 1'b0;
  localparam bit REQ_FREE  = 1'b1;

  typedef enum logic [2:0] {
    K_ALLOC, K_FREE_RAW, K_FREE_LIVE, K_PAUSE, K_PHASE, K_HOLD
  } kind_e;

  typedef struct {
    kind_e       kind;
    int unsigned val;
    int          sel;
  } stim_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             req_type_i;
  logic [REQ_W-1:0] req_size_i;
  logic [REQ_W-1:0] payload_offset_in_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [PAY_W-1:0] payload_offset_o;
  logic [1:0]       status_o;

  heap_block_allocator u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .req_type_i          (req_type_i),
    .req_size_i          (req_size_i),
    .payload_offset_in_i (payload_offset_in_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .payload_offset_o    (payload_offset_o),
    .status_o            (status_o)
  );

  // heap state mirror
  bit          blk_valid [GRAN];
  bit          blk_free  [GRAN];
  int unsigned blk_off   [GRAN];
  int unsigned blk_size  [GRAN];
  int unsigned free_list [SLOTS];
  int unsigned free_cnt;

  logic [PAY_W-1:0] exp_offset_q[$];
  status_e          exp_status_q[$];
  int unsigned      live_q[$];
  stim_t            stim_q[$];

  int unsigned errors;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_req;
  int unsigned hold_left;
  bit          in_took;

  stim_t       cur;
  bit          nv;
  int unsigned drv_off;
  int unsigned pick;

  function automatic int unsigned gidx(input int unsigned off);
    return ((off >> 3) < GRAN) ? (off >> 3) : 0;
  endfunction

  function automatic int unsigned bsz(input int unsigned off);
    return blk_size[gidx(off)];
  endfunction

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    int unsigned t;
    t = free_list[a];
    free_list[a] = free_list[b];
    free_list[b] = t;
  endfunction

  function automatic void sink(input int unsigned i);
    int unsigned best, l, r;
    while (i < free_cnt) begin
      best = i;
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (l < free_cnt && bsz(free_list[l]) < bsz(free_list[best])) best = l;
      if (r < free_cnt && bsz(free_list[r]) < bsz(free_list[best])) best = r;
      if (best == i) break;
      swap_slots(i, best);
      i = best;
    end
  endfunction

  function automatic void push_free(input int unsigned off);
    int unsigned i, p;
    if (free_cnt >= SLOTS) return;
    free_list[free_cnt] = off;
    i = free_cnt;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (bsz(free_list[p]) > bsz(free_list[i])) begin
        swap_slots(p, i);
        i = p;
      end else begin
        break;
      end
    end
    free_cnt++;
  endfunction

  function automatic void pull_slot(input int unsigned i);
    free_list[i] = free_list[free_cnt - 1];
    free_cnt--;
    sink(i);
  endfunction

  function automatic void drop_free(input int unsigned off);
    for (int unsigned i = 0; i < free_cnt; i++) begin
      if (free_list[i] == off) begin
        pull_slot(i);
        return;
      end
    end
  endfunction

  function automatic void coalesce();
    int unsigned at, nxt, c, n;
    at = 0;
    forever begin
      c = gidx(at);
      if (!blk_valid[c] || blk_off[c] != at) break;
      nxt = at + META + blk_size[c];
      if (nxt >= HEAP) break;
      n = gidx(nxt);
      if (!blk_valid[n] || blk_off[n] != nxt) break;
      if (blk_free[c] && blk_free[n]) begin
        drop_free(at);
        drop_free(nxt);
        blk_size[c] += META + blk_size[n];
        blk_valid[n] = 0;
        blk_free[n]  = 0;
        blk_off[n]   = 0;
        blk_size[n]  = 0;
        push_free(at);
      end else begin
        at = nxt;
      end
    end
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < GRAN; i++) begin
      blk_valid[i] = 0;
      blk_free[i]  = 0;
      blk_off[i]   = 0;
      blk_size[i]  = 0;
    end
    for (int i = 0; i < SLOTS; i++) free_list[i] = 0;
    blk_valid[0] = 1;
    blk_free[0]  = 1;
    blk_size[0]  = HEAP - META;
    free_cnt = 1;
  endfunction

  function automatic void heap_request(input bit t, input int unsigned rsz,
                                       input int unsigned ptr);
    int unsigned need, off, noff, b, nb, pay;
    status_e st;
    pay = 0;
    st  = ST_OK;
    if (t == REQ_ALLOC) begin
      if (rsz == 0) begin
        st = ST_ZERO;
      end else begin
        need = (rsz + 7) & ~32'd7;
        st = ST_NOFIT;
        for (int unsigned i = 0; i < free_cnt; i++) begin
          off = free_list[i];
          b = gidx(off);
          if (blk_size[b] >= need) begin
            pull_slot(i);
            if (blk_size[b] >= need + META + 16) begin
              noff = off + META + need;
              nb = gidx(noff);
              blk_valid[nb] = 1;
              blk_free[nb]  = 1;
              blk_off[nb]   = noff;
              blk_size[nb]  = blk_size[b] - need - META;
              blk_size[b]   = need;
              push_free(noff);
            end
            blk_free[b] = 0;
            pay = off + META;
            st = ST_OK;
            live_q.push_back(pay);
            break;
          end
        end
      end
    end else if (ptr != 0) begin
      if (ptr < META || ptr - META >= HEAP) begin
        st = ST_RANGE;
      end else begin
        off = ptr - META;
        b = gidx(off);
        if (!blk_valid[b] || blk_off[b] != off || blk_free[b]) begin
          st = ST_RANGE;
        end else begin
          blk_free[b] = 1;
          push_free(off);
          coalesce();
        end
      end
    end
    exp_offset_q.push_back(pay[PAY_W-1:0]);
    exp_status_q.push_back(st);
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void add(input kind_e k, input int unsigned v, input int s = -1);
    stim_t it;
    it.kind = k;
    it.val  = v;
    it.sel  = s;
    stim_q.push_back(it);
  endfunction

  function automatic int unsigned rand_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) return 0;
    if (r < 72) return $urandom_range(256, 1);
    if (r < 92) return $urandom_range(4096, 257);
    return $urandom_range(131071);
  endfunction

  function automatic void random_items(input int unsigned n);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 52) add(K_ALLOC, rand_size());
      else if (r < 90) add(K_FREE_LIVE, 0);
      else if (r < 95) add(K_FREE_RAW, $urandom_range(131071));
      else add(K_FREE_RAW, 32 + 8 * $urandom_range(200));
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("heap_block_allocator verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o)
        heap_request(req_type_i, 32'(req_size_i), 32'(payload_offset_in_i));
      if (out_valid_o && out_ready_i) begin
        if (exp_offset_q.size() == 0) begin
          report("unexpected result", 32'(status_o), 0);
        end else begin
          if (payload_offset_o !== exp_offset_q[0])
            report("payload_offset", 32'(payload_offset_o), 32'(exp_offset_q[0]));
          if (status_o !== exp_status_q[0])
            report("status", 32'(status_o), 32'(exp_status_q[0]));
          void'(exp_offset_q.pop_front());
          void'(exp_status_q.pop_front());
        end
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      nv = 1'b0;
      if (stim_q.size() > 0) begin
        cur = stim_q[0];
        case (cur.kind)
          K_PAUSE: begin
            if (exp_offset_q.size() == 0) void'(stim_q.pop_front());
          end
          K_PHASE: begin
            tx_idle_pct = cur.val;
            rx_idle_pct = cur.sel;
            void'(stim_q.pop_front());
          end
          K_HOLD: begin
            hold_req = 1'b1;
            void'(stim_q.pop_front());
          end
          default: begin
            if ($urandom_range(99) >= tx_idle_pct) begin
              void'(stim_q.pop_front());
              nv = 1'b1;
              drv_off = cur.val;
              if (cur.kind == K_FREE_LIVE) begin
                if (live_q.size() > 0) begin
                  pick = (cur.sel >= 0 && cur.sel < live_q.size()) ? cur.sel :
                         $urandom_range(live_q.size() - 1);
                  drv_off = live_q[pick];
                  live_q.delete(pick);
                end else begin
                  drv_off = $urandom_range(131071);
                end
              end
            end
          end
        endcase
      end
      in_valid_i <= nv;
      if (nv) begin
        req_type_i          <= (cur.kind == K_ALLOC) ? REQ_ALLOC : REQ_FREE;
        req_size_i          <= REQ_W'((cur.kind == K_ALLOC) ? cur.val :
                                      $urandom_range(131071));
        payload_offset_in_i <= REQ_W'((cur.kind == K_ALLOC) ? $urandom_range(131071) :
                                      drv_off);
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    errors = 0;
    in_took = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    in_valid_i = 1'b0;
    req_type_i = REQ_ALLOC;
    req_size_i = '0;
    payload_offset_in_i = '0;
    out_ready_i = 1'b0;
    heap_reset();

    add(K_PHASE, 21, 82);
    add(K_ALLOC, 0);
    add(K_ALLOC, 1);
    add(K_ALLOC, 65536);
    add(K_ALLOC, 131071);
    add(K_FREE_RAW, 0);
    add(K_FREE_RAW, 1);
    add(K_FREE_RAW, 31);
    add(K_FREE_RAW, 131071);
    add(K_FREE_RAW, 65568);
    add(K_FREE_RAW, 40);
    add(K_ALLOC, 8);
    add(K_ALLOC, 100);
    add(K_FREE_LIVE, 0, 1);
    add(K_FREE_LIVE, 0);
    add(K_FREE_LIVE, 0);
    add(K_FREE_RAW, 32);
    add(K_ALLOC, 65504);
    add(K_FREE_LIVE, 0);
    add(K_ALLOC, 65480);
    add(K_FREE_LIVE, 0);
    add(K_PAUSE, 0);

    // fragment the heap so the free list overflows
    for (int i = 0; i < 140; i++) add(K_ALLOC, 8);
    add(K_HOLD, 0);
    for (int i = 138; i >= 0; i -= 2) add(K_FREE_LIVE, 0, i);
    add(K_PAUSE, 0);
    random_items(40);

    add(K_PHASE, 82, 21);
    random_items(50);
    add(K_PAUSE, 0);
    add(K_HOLD, 0);
    random_items(30);

    add(K_PHASE, 0, 0);
    random_items(50);

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stim_q.size() > 0 || in_valid_i || exp_offset_q.size() > 0)
      @(posedge clk_i);
    repeat (2000) @(posedge clk_i);

    if (errors == 0) begin
      $display("heap_block_allocator verification clean");
    end else begin
      $display("heap_block_allocator verification failed");
    end
    $finish;
  end

endmodule
